// ----- rtl/ptfl_pkg.sv -----
// Package for the periodic time feature lifter: widths, register indexes,
// CORDIC angle table and shared types. No dependencies.
package ptfl_pkg;

	localparam int MAX_PERIODS = 4;
	localparam int PHASE_BITS = 16;
	localparam int CORDIC_STEPS = 18;
	localparam int Q16_ONE = 65536;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PERIODS_USED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_D = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_OFFSET = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE = 3'd6;

	// Angle of each CORDIC step in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		case (i)
			5'd0: atan_turn = 32'd536870912;
			5'd1: atan_turn = 32'd316933406;
			5'd2: atan_turn = 32'd167458907;
			5'd3: atan_turn = 32'd85004757;
			5'd4: atan_turn = 32'd42667331;
			5'd5: atan_turn = 32'd21354465;
			5'd6: atan_turn = 32'd10679838;
			5'd7: atan_turn = 32'd5340245;
			5'd8: atan_turn = 32'd2670163;
			5'd9: atan_turn = 32'd1335087;
			5'd10: atan_turn = 32'd667544;
			5'd11: atan_turn = 32'd333772;
			5'd12: atan_turn = 32'd166886;
			5'd13: atan_turn = 32'd83443;
			5'd14: atan_turn = 32'd41722;
			5'd15: atan_turn = 32'd20861;
			5'd16: atan_turn = 32'd10430;
			5'd17: atan_turn = 32'd5215;
			default: atan_turn = 32'd0;
		endcase
	endfunction

	typedef struct packed {
		logic [31:0] time_value;
		logic end_of_batch;
	} in_item_t;

	typedef struct packed {
		logic [2:0] group_index;
		logic is_polynomial;
		logic signed [31:0] first_value;
		logic signed [31:0] second_value;
		logic signed [31:0] third_value;
		logic sample_last;
		logic batch_end;
	} out_item_t;

	// Work carried by one cell: remainder/phase division state for a period.
	typedef struct packed {
		logic vld;
		logic [31:0] rem;
		logic [PHASE_BITS-1:0] quo;
	} div_t;

	typedef struct packed {
		logic vld;
		logic [1:0] quad;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} rot_t;

endpackage

// ----- rtl/ptfl_if.sv -----
// Valid/ready channel interfaces for the lifter.
// Depends on ptfl_pkg for the payload types.
interface ptfl_in_if import ptfl_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ptfl_out_if import ptfl_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/periodic_time_feature_lifter_unit.sv -----
// Top level of the periodic time feature lifter.
// Throughput: one item issues per cycle while result credits last; a sample gives
// (periods in use + 1) items, at most five. There are eight credits: one is taken
// at each issue and given back when a result leaves the queue.
// Reset: all pipelines empty, registers at periods_used 1, periods 1, else 0.
module periodic_time_feature_lifter_unit import ptfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	ptfl_in_if.sink in_ch,
	ptfl_out_if.source out_ch
);
	localparam int DIV_N = 32 + PHASE_BITS;
	localparam int NST = DIV_N + CORDIC_STEPS + 2;
	localparam int QD = 8;

	logic [2:0] periods_used_q;
	logic [31:0] period_q [MAX_PERIODS];
	logic [31:0] centre_q, scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periods_used_q <= 3'd1;
			for (int i = 0; i < MAX_PERIODS; i++) period_q[i] <= 32'd1;
			centre_q <= '0;
			scale_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_PERIODS_USED) periods_used_q <= cfg_data[2:0];
			else if (cfg_index >= REG_PERIOD_A && cfg_index <= REG_PERIOD_D)
				period_q[2'(cfg_index - REG_PERIOD_A)] <= cfg_data;
			else if (cfg_index == REG_CENTRE_OFFSET) centre_q <= cfg_data;
			else if (cfg_index == REG_RANGE_SCALE) scale_q <= cfg_data;
		end
	end

	logic [2:0] used;
	assign used = (periods_used_q > 3'(MAX_PERIODS)) ? 3'(MAX_PERIODS) : periods_used_q;

	// Issue: one item per cycle while credits last, sample held while its items are issued.
	logic busy_q;
	logic [2:0] slot_q;
	in_item_t smp_q;
	logic [3:0] credits_q;
	logic issue, last_slot, go;
	logic pop;

	assign last_slot = (slot_q == used);
	assign go = busy_q && (credits_q != 4'd0);
	assign issue = go;
	assign in_ch.ready = !busy_q || (go && last_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				busy_q <= 1'b1;
				slot_q <= '0;
			end else if (go && last_slot) begin
				busy_q <= 1'b0;
			end else if (go) begin
				slot_q <= slot_q + 3'd1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) smp_q <= in_ch.data;
	end

	// Pipeline sideband per stage.
	typedef struct packed {
		logic vld;
		logic poly;
		logic [2:0] grp;
		logic eob;
		logic [31:0] per;
		logic [31:0] t;
		logic zero;
	} side_t;

	side_t side_s [NST+1];
	div_t dv [DIV_N+1];
	rot_t rt [CORDIC_STEPS+1];

	always_comb begin
		side_s[0].vld = issue;
		side_s[0].poly = last_slot;
		side_s[0].grp = slot_q;
		side_s[0].eob = smp_q.end_of_batch;
		side_s[0].per = period_q[slot_q[1:0]];
		side_s[0].t = smp_q.time_value;
		side_s[0].zero = (period_q[slot_q[1:0]] == 32'd0);
		dv[0].vld = issue;
		dv[0].rem = '0;
		dv[0].quo = '0;
	end

	genvar g;
	for (g = 0; g < NST; g++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_s[g+1] <= '0;
			else side_s[g+1] <= side_s[g];
		end
	end

	for (g = 0; g < DIV_N; g++) begin : g_div
		ptfl_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(1'b1),
			.phase_step(g >= 32),
			.per(side_s[g].per), .tbit_word(side_s[g].t),
			.step(6'(g)), .din(dv[g]), .dout(dv[g+1])
		);
	end

	logic [31:0] angle;
	always_comb begin
		angle = {(side_s[DIV_N].zero ? {PHASE_BITS{1'b0}} : dv[DIV_N].quo),
			{(32-PHASE_BITS){1'b0}}};
		rt[0].vld = dv[DIV_N].vld;
		rt[0].quad = angle[31:30];
		rt[0].x = 34'sd652032874;
		rt[0].y = '0;
		rt[0].z = $signed({4'b0000, angle[29:0]});
	end

	for (g = 0; g < CORDIC_STEPS; g++) begin : g_rot
		ptfl_rot_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(1'b1),
			.step(5'(g)), .din(rt[g]), .dout(rt[g+1])
		);
	end

	localparam int RS = DIV_N + CORDIC_STEPS;

	// Round and fold quadrant.
	function automatic logic signed [31:0] q16(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = (v + 34'sd8192) >>> 14;
		if (r > 34'sd65536) r = 34'sd65536;
		if (r < -34'sd65536) r = -34'sd65536;
		q16 = r[31:0];
	endfunction

	logic signed [31:0] cq_s1, sq_s1, c_s2, s_s2;
	logic [1:0] quad_s1;
	always_ff @(posedge clk) begin
		cq_s1 <= q16(rt[CORDIC_STEPS].x);
		sq_s1 <= q16(rt[CORDIC_STEPS].y);
		quad_s1 <= rt[CORDIC_STEPS].quad;
		case (quad_s1)
			2'd0: begin c_s2 <= cq_s1; s_s2 <= sq_s1; end
			2'd1: begin c_s2 <= -sq_s1; s_s2 <= cq_s1; end
			2'd2: begin c_s2 <= -cq_s1; s_s2 <= -sq_s1; end
			default: begin c_s2 <= sq_s1; s_s2 <= -cq_s1; end
		endcase
	end

	// Polynomial path, computed over the last stages from the carried time.
	logic neg_s1;
	logic [31:0] mag_s1;
	logic [63:0] prod_s2;
	logic neg_s2;
	logic signed [31:0] v_s3;
	logic [31:0] m_s3;
	logic [63:0] sqp_s4;
	logic signed [31:0] v_s4;
	logic [32:0] d;
	logic [47:0] rq;
	logic [47:0] sqr;
	assign d = {1'b0, side_s[RS-2].t} - {1'b0, centre_q};
	assign rq = 48'((prod_s2 + 64'd32768) >> 16);
	assign sqr = 48'((sqp_s4 + 64'd32768) >> 16);
	always_ff @(posedge clk) begin
		neg_s1 <= d[32];
		mag_s1 <= d[32] ? 32'(-d) : d[31:0];
		prod_s2 <= 64'(mag_s1) * 64'(scale_q);
		neg_s2 <= neg_s1;
		if (neg_s2) v_s3 <= (rq > 48'h80000000) ? 32'sh80000000 : -$signed(rq[31:0]);
		else v_s3 <= (rq > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(rq[31:0]);
		m_s3 <= 32'(neg_s2 ? ((rq > 48'h80000000) ? 48'h80000000 : rq) :
			((rq > 48'h7FFFFFFF) ? 48'h7FFFFFFF : rq));
		sqp_s4 <= 64'(m_s3) * 64'(m_s3);
		v_s4 <= v_s3;
	end

	// Align: trig values appear at RS+2, poly at RS+2 as well (sqp at s4 => RS+2).
	out_item_t res;
	side_t fin;
	assign fin = side_s[RS+2];
	always_comb begin
		res.group_index = fin.grp;
		res.is_polynomial = fin.poly;
		res.first_value = fin.poly ? v_s4 : c_s2;
		res.second_value = fin.poly ? ((sqr > 48'h7FFFFFFF) ? 32'sh7FFFFFFF
			: $signed(sqr[31:0])) : s_s2;
		res.third_value = 32'sd65536;
		res.sample_last = fin.poly;
		res.batch_end = fin.poly & fin.eob;
	end

	// Result queue with credits so the chain never overruns it.
	out_item_t fifo_q [QD];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;
	assign pop = out_ch.valid && out_ch.ready;
	assign out_ch.valid = (cnt_q != 4'd0);
	assign out_ch.data = fifo_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			credits_q <= 4'(QD);
		end else begin
			if (fin.vld) wp_q <= wp_q + 3'd1;
			if (pop) rp_q <= rp_q + 3'd1;
			cnt_q <= cnt_q + 4'(fin.vld) - 4'(pop);
			credits_q <= credits_q - 4'(issue) + 4'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (fin.vld) fifo_q[wp_q] <= res;
	end
endmodule

// ----- rtl/ptfl_div_cell.sv -----
// One cell of the phase divider chain: a restoring step of the modulo or of
// the phase quotient. Depends on ptfl_pkg.
module ptfl_div_cell import ptfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic phase_step,
	input logic [31:0] per,
	input logic [31:0] tbit_word,
	input logic [5:0] step,
	input div_t din,
	output div_t dout
);
	logic [32:0] trial;
	logic [32:0] sh;
	always_comb begin
		if (phase_step) sh = {din.rem, 1'b0};
		else sh = {din.rem, tbit_word[5'(31 - step)]};
		trial = sh - {1'b0, per};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout.vld <= din.vld;
			if (!trial[32]) dout.rem <= trial[31:0];
			else dout.rem <= sh[31:0];
			if (phase_step) dout.quo <= {din.quo[PHASE_BITS-2:0], ~trial[32]};
			else dout.quo <= din.quo;
		end
	end
endmodule

// ----- rtl/ptfl_rot_cell.sv -----
// One CORDIC rotation cell of the sine-cosine chain.
// Depends on ptfl_pkg for the angle table.
module ptfl_rot_cell import ptfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [4:0] step,
	input rot_t din,
	output rot_t dout
);
	logic signed [33:0] dx, dy, at;
	always_comb begin
		dx = din.y >>> step;
		dy = din.x >>> step;
		at = $signed({2'b00, atan_turn(step)});
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout.vld <= din.vld;
			dout.quad <= din.quad;
			if (!din.z[33]) begin
				dout.x <= din.x - dx;
				dout.y <= din.y + dy;
				dout.z <= din.z - at;
			end else begin
				dout.x <= din.x + dx;
				dout.y <= din.y - dy;
				dout.z <= din.z + at;
			end
		end
	end
endmodule

// ----- bench/ptfl_checker.sv -----
// Checker for the periodic time feature lifter: watches the register port and
// both channels, predicts every feature item and compares. Depends on ptfl_pkg, ptfl_if.
`timescale 1ns / 100ps
module ptfl_checker import ptfl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	ptfl_in_if in_ch,
	ptfl_out_if out_ch,
	output int mismatches,
	output int pending
);

	// Rotation angles atan(2^-i) in units of 2^-32 turn.
	localparam longint ROT_ANGLE [18] = '{
		536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215};

	logic [2:0] n_periods;
	logic [31:0] period_len [4];
	logic [31:0] centre;
	logic [31:0] scale;
	out_item_t expected_features [$];

	function automatic longint round_q16(input longint q30);
		longint r;
		r = (q30 + 8192) >>> 14;
		if (r > Q16_ONE) r = Q16_ONE;
		if (r < -Q16_ONE) r = -Q16_ONE;
		return r;
	endfunction

	// Rotation on the quarter-turn part of the angle, then quadrant folding.
	function automatic void rotate(input logic [31:0] angle, output longint c,
			output longint s);
		longint x, y, z, dx, dy, cq, sq;
		x = 652032874;
		y = 0;
		z = longint'(angle[29:0]);
		for (int i = 0; i < 18; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ROT_ANGLE[i];
			end else begin
				x += dx; y -= dy; z += ROT_ANGLE[i];
			end
		end
		cq = round_q16(x);
		sq = round_q16(y);
		case (angle[31:30])
			2'd0: begin c = cq; s = sq; end
			2'd1: begin c = -sq; s = cq; end
			2'd2: begin c = -cq; s = -sq; end
			default: begin c = sq; s = -cq; end
		endcase
	endfunction

	task automatic predict_features(input in_item_t smp);
		int used;
		out_item_t f;
		logic [63:0] ph, mag, rq, m, sq;
		logic [31:0] angle;
		longint c, s, d, v;
		used = (n_periods > MAX_PERIODS) ? MAX_PERIODS : n_periods;
		for (int p = 0; p < used; p++) begin
			ph = 0;
			if (period_len[p] != 0)
				ph = (64'(smp.time_value % period_len[p]) << PHASE_BITS) / period_len[p];
			angle = 32'(ph << (32 - PHASE_BITS));
			rotate(angle, c, s);
			f = '0;
			f.group_index = 3'(p);
			f.first_value = 32'(c);
			f.second_value = 32'(s);
			f.third_value = Q16_ONE;
			expected_features = {expected_features, f};
		end
		d = longint'(smp.time_value) - longint'(centre);
		mag = (d < 0) ? 64'(-d) : 64'(d);
		rq = (mag * 64'(scale) + 64'd32768) >> 16;
		if (d < 0) v = (rq > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(rq);
		else v = (rq > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(rq);
		m = (v < 0) ? 64'(-v) : 64'(v);
		sq = (m * m + 64'd32768) >> 16;
		if (sq > 64'h7FFF_FFFF) sq = 64'h7FFF_FFFF;
		f.group_index = 3'(used);
		f.is_polynomial = 1'b1;
		f.first_value = 32'(v);
		f.second_value = 32'(sq);
		f.third_value = Q16_ONE;
		f.sample_last = 1'b1;
		f.batch_end = smp.end_of_batch;
		expected_features = {expected_features, f};
	endtask

	task automatic field_check(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: mismatch in %s: expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want, got;
		if (!arst_n) begin
			n_periods <= 3'd1;
			for (int i = 0; i < 4; i++) period_len[i] <= 32'd1;
			centre <= '0;
			scale <= '0;
			mismatches = 0;
			pending = 0;
			expected_features.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PERIODS_USED) n_periods <= cfg_data[2:0];
				else if (cfg_index >= REG_PERIOD_A && cfg_index <= REG_PERIOD_D)
					period_len[cfg_index - REG_PERIOD_A] <= cfg_data;
				else if (cfg_index == REG_CENTRE_OFFSET) centre <= cfg_data;
				else if (cfg_index == REG_RANGE_SCALE) scale <= cfg_data;
			end
			if (in_ch.valid && in_ch.ready)
				predict_features(in_ch.data);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_features.size() == 0) begin
					$display("%0t ns: unexpected transfer: expected none, got %p", $time, got);
					mismatches++;
				end else begin
					want = expected_features.pop_front();
					field_check("group_index", want.group_index, got.group_index);
					field_check("is_polynomial", want.is_polynomial, got.is_polynomial);
					field_check("first_value", want.first_value, got.first_value);
					field_check("second_value", want.second_value, got.second_value);
					field_check("third_value", want.third_value, got.third_value);
					field_check("sample_last", want.sample_last, got.sample_last);
					field_check("batch_end", want.batch_end, got.batch_end);
				end
			end
			pending = expected_features.size();
		end
	end

endmodule

// ----- bench/tb_periodic_time_feature_lifter_unit.sv -----
// Testbench top for periodic_time_feature_lifter_unit: directed and random
// samples over several register settings. Depends on ptfl_pkg, ptfl_if, ptfl_checker.
`timescale 1ns / 100ps
module tb_periodic_time_feature_lifter_unit;
	import ptfl_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int mismatches, pending;
	int cycles = 0;
	int burst_left = 0;
	int hold_seq = 0;
	logic [31:0] centre_now = '0;

	ptfl_in_if in_ch ();
	ptfl_out_if out_ch ();

	periodic_time_feature_lifter_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch));

	ptfl_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
		.mismatches(mismatches), .pending(pending));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: stall pattern drawn at random from four kinds; a long hold-off on request.
	always @(negedge clk) begin
		int seen_hold, hold_left, pattern;
		if (hold_seq != seen_hold) begin
			seen_hold = hold_seq;
			hold_left = 300;
		end
		if (cycles % 64 == 0) pattern = $urandom_range(0, 3);
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case (pattern)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= (cycles % 3 == 0);
			endcase
		end
	end

	task automatic send_sample(input logic [31:0] t, input logic eob);
		int gap;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= '{time_value: t, end_of_batch: eob};
		do @(posedge clk); while (!in_ch.ready);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Waits until every expected item has arrived, then lets the pipeline empty.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_CENTRE_OFFSET) centre_now = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3: return $urandom_range(1, 16);
			default: return $urandom_range(1, 5000);
		endcase
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 5000);
			2: return centre_now + 32'($urandom_range(0, 4000)) - 32'd2000;
			default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
		endcase
	endfunction

	task automatic random_settings();
		write_reg(REG_PERIODS_USED, $urandom);
		for (int i = 0; i < 4; i++) write_reg(REG_PERIOD_A + 3'(i), pick_period());
		write_reg(REG_CENTRE_OFFSET, ($urandom_range(0, 1) != 0) ? $urandom
			: 32'($urandom_range(0, 5000)));
		case ($urandom_range(0, 2))
			0: write_reg(REG_RANGE_SCALE, $urandom);
			1: write_reg(REG_RANGE_SCALE, $urandom_range(0, 32'h0100_0000));
			default: write_reg(REG_RANGE_SCALE, $urandom_range(0, 32'h0000_4000));
		endcase
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: one period of length one, zero scale.
		send_sample(32'd0, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);
		send_sample(32'd12345, 1'b0);
		settle();

		// All four periods, a zero period, widest period, saturating scale.
		write_reg(REG_PERIODS_USED, 32'd4);
		write_reg(REG_PERIOD_A, 32'd0);
		write_reg(REG_PERIOD_B, 32'hFFFF_FFFF);
		write_reg(REG_PERIOD_C, 32'd360);
		write_reg(REG_PERIOD_D, 32'd7);
		write_reg(REG_CENTRE_OFFSET, 32'h8000_0000);
		write_reg(REG_RANGE_SCALE, 32'hFFFF_FFFF);
		send_sample(32'd0, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
		send_sample(32'h8000_0001, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'd90, 1'b0);
		send_sample(32'd180, 1'b1);
		send_sample(32'd270, 1'b0);
		settle();

		// More periods requested than exist; small scale near the centre.
		write_reg(REG_PERIODS_USED, 32'd7);
		write_reg(REG_CENTRE_OFFSET, 32'd1000);
		write_reg(REG_RANGE_SCALE, 32'h0040_0000);
		send_sample(32'd1000, 1'b0);
		send_sample(32'd999, 1'b1);
		send_sample(32'd1001, 1'b0);
		send_sample(32'd0, 1'b0);
		send_sample(32'h0010_0000, 1'b1);
		settle();

		// No periods: only the polynomial item, square saturating.
		write_reg(REG_PERIODS_USED, 32'd0);
		write_reg(REG_CENTRE_OFFSET, 32'd0);
		write_reg(REG_RANGE_SCALE, 32'h0100_0000);
		send_sample(32'd0, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0080_0000, 1'b1);
		send_sample(32'd3, 1'b0);
		settle();

		for (int phase = 0; phase < 6; phase++) begin
			random_settings();
			if (phase == 2) hold_seq++;
			for (int i = 0; i < 15; i++)
				send_sample(pick_time(), $urandom_range(0, 1));
			settle();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ptfl_pkg.sv
rtl/ptfl_if.sv
rtl/ptfl_div_cell.sv
rtl/ptfl_rot_cell.sv
rtl/periodic_time_feature_lifter_unit.sv
bench/ptfl_checker.sv
bench/tb_periodic_time_feature_lifter_unit.sv
